// ----- sv/ftkl_pkg.sv -----
// Shared types and constants for the field table key lookup block.
// Holds the result record, parse phases, type and error codes, register indexes.
// No dependencies.
`timescale 1ns / 1ps

package ftkl_pkg;

  localparam int MAX_KEY_BYTES  = 32;
  localparam int MAX_NAME_BYTES = 255;
  localparam int KEY_WORDS      = 4;
  localparam int KEY_WORD_W     = 64;
  localparam int KEY_BITS       = KEY_WORDS * KEY_WORD_W;
  localparam int KEY_IDX_W      = $clog2(MAX_KEY_BYTES);
  localparam int CFG_INDEX_W    = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES_0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES_1 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES_2 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES_3 = 3'd4;

  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_I = 8'h49;
  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_T = 8'h54;

  localparam logic [2:0] TYPE_NONE    = 3'd0;
  localparam logic [2:0] TYPE_STRING  = 3'd1;
  localparam logic [2:0] TYPE_INTEGER = 3'd2;
  localparam logic [2:0] TYPE_DECIMAL = 3'd3;
  localparam logic [2:0] TYPE_TIME    = 3'd4;

  localparam logic [1:0] ERR_OK          = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED   = 2'd1;
  localparam logic [1:0] ERR_UNSUPPORTED = 2'd2;

  typedef enum logic [7:0] {
    PH_NAME_LEN = 8'b0000_0001,
    PH_NAME     = 8'b0000_0010,
    PH_TYPE     = 8'b0000_0100,
    PH_LEN_HI   = 8'b0000_1000,
    PH_LEN_LO   = 8'b0001_0000,
    PH_BODY     = 8'b0010_0000,
    PH_DECIMALS = 8'b0100_0000,
    PH_DONE     = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [5:0]          length;
    logic [KEY_BITS-1:0] bytes;
  } key_t;

  typedef struct packed {
    logic               found;
    logic [2:0]         field_kind;
    logic [15:0]        data_offset;
    logic [15:0]        string_length;
    logic [7:0]         decimal_places;
    logic signed [31:0] field_value;
    logic [1:0]         error_code;
  } result_t;

endpackage

// ----- sv/ftkl_key_regs.sv -----
// Configuration registers holding the searched key length and key bytes.
// Depends on ftkl_pkg.
`timescale 1ns / 1ps

module ftkl_key_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ftkl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ftkl_pkg::KEY_WORD_W-1:0]  cfg_data,
  output ftkl_pkg::key_t                   key
);
  import ftkl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LENGTH:  key.length <= cfg_data[5:0];
        CFG_KEY_BYTES_0: key.bytes[0*KEY_WORD_W +: KEY_WORD_W] <= cfg_data;
        CFG_KEY_BYTES_1: key.bytes[1*KEY_WORD_W +: KEY_WORD_W] <= cfg_data;
        CFG_KEY_BYTES_2: key.bytes[2*KEY_WORD_W +: KEY_WORD_W] <= cfg_data;
        CFG_KEY_BYTES_3: key.bytes[3*KEY_WORD_W +: KEY_WORD_W] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/ftkl_parser.sv -----
// Byte-at-a-time field table parser: phase state, counters and key compare.
// Emits at most one result per accepted byte. Depends on ftkl_pkg.
`timescale 1ns / 1ps

module ftkl_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       table_byte,
  input  logic             last_byte,
  input  ftkl_pkg::key_t   key,
  output logic             res_valid,
  output ftkl_pkg::result_t res
);
  import ftkl_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] pos, pos_next;
  logic [15:0] remaining, remaining_next;
  logic [7:0]  name_index, name_index_next;
  logic        name_matches, name_matches_next;
  logic [2:0]  cur_type, cur_type_next;
  logic [31:0] value, value_next;
  logic [7:0]  decimals, decimals_next;

  logic        finish;
  logic [15:0] field_len;
  logic [7:0]  key_byte;

  assign key_byte = key.bytes[{name_index[KEY_IDX_W-1:0], 3'b000} +: 8];

  always_comb begin
    phase_next        = phase;
    pos_next          = pos;
    remaining_next    = remaining;
    name_index_next   = name_index;
    name_matches_next = name_matches;
    cur_type_next     = cur_type;
    value_next        = value;
    decimals_next     = decimals;
    finish            = 1'b0;
    field_len         = 16'd4;
    res_valid         = 1'b0;
    res               = '0;

    if (accept) begin
      unique case (phase)
        PH_NAME_LEN: begin
          remaining_next    = {8'd0, table_byte};
          name_index_next   = '0;
          name_matches_next = (table_byte == {2'b00, key.length}) &&
                              (table_byte <= 8'(MAX_KEY_BYTES)) &&
                              (table_byte <= 8'(MAX_NAME_BYTES));
          phase_next        = (table_byte != 8'd0) ? PH_NAME : PH_TYPE;
        end
        PH_NAME: begin
          if (name_matches) begin
            if (name_index < 8'(MAX_KEY_BYTES)) begin
              if (key_byte != table_byte) name_matches_next = 1'b0;
            end else begin
              name_matches_next = 1'b0;
            end
          end
          name_index_next = name_index + 8'd1;
          remaining_next  = remaining - 16'd1;
          if (remaining_next == 16'd0) phase_next = PH_TYPE;
        end
        PH_TYPE: begin
          value_next    = '0;
          decimals_next = '0;
          priority if (table_byte == CHAR_S) begin
            cur_type_next = TYPE_STRING;
            phase_next    = PH_LEN_HI;
          end else if (table_byte == CHAR_I || table_byte == CHAR_T) begin
            cur_type_next  = (table_byte == CHAR_I) ? TYPE_INTEGER : TYPE_TIME;
            remaining_next = 16'd4;
            phase_next     = PH_BODY;
          end else if (table_byte == CHAR_D) begin
            cur_type_next = TYPE_DECIMAL;
            phase_next    = PH_DECIMALS;
          end else begin
            cur_type_next  = TYPE_NONE;
            res_valid      = 1'b1;
            res.error_code = ERR_UNSUPPORTED;
            phase_next     = PH_DONE;
          end
        end
        PH_LEN_HI: begin
          value_next = {24'd0, table_byte};
          phase_next = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          value_next     = {16'd0, value[7:0], table_byte};
          remaining_next = value_next[15:0];
          if (remaining_next == 16'd0) finish = 1'b1;
          else phase_next = PH_BODY;
        end
        PH_DECIMALS: begin
          decimals_next  = table_byte;
          remaining_next = 16'd4;
          phase_next     = PH_BODY;
        end
        PH_BODY: begin
          if (cur_type != TYPE_STRING) value_next = {value[23:0], table_byte};
          remaining_next = remaining - 16'd1;
          if (remaining_next == 16'd0) finish = 1'b1;
        end
        PH_DONE: ;
        default: ;
      endcase

      if (finish) begin
        if (!name_matches) begin
          phase_next = PH_NAME_LEN;
        end else begin
          unique case (cur_type)
            TYPE_STRING:  field_len = value_next[15:0] + 16'd2;
            TYPE_DECIMAL: field_len = 16'd5;
            default:      field_len = 16'd4;
          endcase
          res_valid       = 1'b1;
          res.found       = 1'b1;
          res.field_kind  = cur_type;
          res.data_offset = pos + 16'd1 - field_len;
          res.error_code  = ERR_OK;
          if (cur_type == TYPE_STRING) begin
            res.string_length = value_next[15:0];
          end else begin
            res.field_value = value_next;
          end
          if (cur_type == TYPE_DECIMAL) res.decimal_places = decimals;
          phase_next = PH_DONE;
        end
      end

      pos_next = pos + 16'd1;

      if (last_byte) begin
        if (!res_valid && phase_next != PH_DONE) begin
          res_valid      = 1'b1;
          res            = '0;
          res.error_code = (phase_next == PH_NAME_LEN) ? ERR_OK : ERR_TRUNCATED;
        end
        phase_next        = PH_NAME_LEN;
        pos_next          = '0;
        remaining_next    = '0;
        name_index_next   = '0;
        name_matches_next = 1'b1;
        cur_type_next     = TYPE_NONE;
        value_next        = '0;
        decimals_next     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_NAME_LEN;
      pos          <= '0;
      remaining    <= '0;
      name_index   <= '0;
      name_matches <= 1'b1;
      cur_type     <= TYPE_NONE;
      value        <= '0;
      decimals     <= '0;
    end else begin
      phase        <= phase_next;
      pos          <= pos_next;
      remaining    <= remaining_next;
      name_index   <= name_index_next;
      name_matches <= name_matches_next;
      cur_type     <= cur_type_next;
      value        <= value_next;
      decimals     <= decimals_next;
    end
  end

endmodule

// ----- sv/ftkl_out_buf.sv -----
// Result register with a skid entry between parser and output channel.
// Depends on ftkl_pkg.
`timescale 1ns / 1ps

module ftkl_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  ftkl_pkg::result_t res,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output ftkl_pkg::result_t out_res
);
  import ftkl_pkg::*;

  logic    main_valid;
  result_t main_res;
  logic    skid_valid;
  result_t skid_res;

  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || !out_stall) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= res_valid;
      end else begin
        main_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || !out_stall) begin
      if (skid_valid) begin
        main_res <= skid_res;
        skid_res <= res;
      end else begin
        main_res <= res;
      end
    end else if (res_valid) begin
      skid_res <= res;
    end
  end

endmodule

// ----- sv/field_table_key_lookup.sv -----
// Field table key lookup: one table byte per cycle while in_stall is low; the
// result of the deciding byte is registered in the result buffer. The parser
// state register updates every accepted byte and a two-entry result buffer
// absorbs output stalls. Synchronous active-high reset clears parser, buffer
// and keys. Depends on ftkl_pkg, ftkl_key_regs, ftkl_parser, ftkl_out_buf.
`timescale 1ns / 1ps

module field_table_key_lookup (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       table_byte,
  input  logic                             last_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             found,
  output logic [2:0]                       field_kind,
  output logic [15:0]                      data_offset,
  output logic [15:0]                      string_length,
  output logic [7:0]                       decimal_places,
  output logic signed [31:0]               field_value,
  output logic [1:0]                       error_code,
  input  logic                             cfg_we,
  input  logic [ftkl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ftkl_pkg::KEY_WORD_W-1:0]  cfg_data
);
  import ftkl_pkg::*;

  key_t    key;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  ftkl_key_regs u_key_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  ftkl_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .table_byte (table_byte),
    .last_byte  (last_byte),
    .key        (key),
    .res_valid  (res_valid),
    .res        (res)
  );

  ftkl_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign found          = out_res.found;
  assign field_kind     = out_res.field_kind;
  assign data_offset    = out_res.data_offset;
  assign string_length  = out_res.string_length;
  assign decimal_places = out_res.decimal_places;
  assign field_value    = out_res.field_value;
  assign error_code     = out_res.error_code;

`ifndef SYNTH
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_found_is_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (error_code == ERR_OK && field_kind != TYPE_NONE))
    else $error("found result with error or no type");

  a_error_is_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != ERR_OK) |-> (!found && field_kind == TYPE_NONE))
    else $error("error result carries field data");
`endif

endmodule

// ----- dv/field_table_key_lookup_test.sv -----
// Testbench for field_table_key_lookup: streams encoded field tables under
// random input gaps and output stalls and checks every result transaction
// against a cycle-free predictor of the parser. Depends on ftkl_pkg and the RTL.
`timescale 1ns / 1ps

module field_table_key_lookup_test;
  import ftkl_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             table_byte;
  logic                   last_byte;
  logic                   out_valid;
  logic                   out_stall;
  logic                   found;
  logic [2:0]             field_kind;
  logic [15:0]            data_offset;
  logic [15:0]            string_length;
  logic [7:0]             decimal_places;
  logic signed [31:0]     field_value;
  logic [1:0]             error_code;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [KEY_WORD_W-1:0]  cfg_data;

  field_table_key_lookup dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .table_byte(table_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .field_kind(field_kind), .data_offset(data_offset),
    .string_length(string_length), .decimal_places(decimal_places),
    .field_value(field_value), .error_code(error_code),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Lookup predictor state
  phase_t      ph;
  logic [15:0] pos_cnt;
  logic [15:0] remain;
  logic [7:0]  name_idx;
  bit          name_ok;
  logic [2:0]  cur_type;
  logic [31:0] shift_val;
  logic [7:0]  held_dec;
  logic [5:0]  key_len;
  logic [63:0] key_words [KEY_WORDS];

  result_t     lookup_results_q[$];
  logic [7:0]  tbl[$];
  int          err_count;
  int          results_seen;
  int          bytes_sent;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [7:0] key_byte(input int i);
    return key_words[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic void clear_parse();
    ph        = PH_NAME_LEN;
    pos_cnt   = '0;
    remain    = '0;
    name_idx  = '0;
    name_ok   = 1'b1;
    cur_type  = TYPE_NONE;
    shift_val = '0;
    held_dec  = '0;
  endfunction

  function automatic bit close_field(input logic [15:0] pos, output result_t res);
    logic [15:0] span;
    res = '0;
    if (!name_ok) begin
      ph = PH_NAME_LEN;
      return 1'b0;
    end
    if (cur_type == TYPE_STRING) span = shift_val[15:0] + 16'd2;
    else if (cur_type == TYPE_DECIMAL) span = 16'd5;
    else span = 16'd4;
    res.found       = 1'b1;
    res.field_kind  = cur_type;
    res.data_offset = pos + 16'd1 - span;
    if (cur_type == TYPE_STRING) begin
      res.string_length = shift_val[15:0];
    end else begin
      res.field_value = shift_val;
      if (cur_type == TYPE_DECIMAL) res.decimal_places = held_dec;
    end
    ph = PH_DONE;
    return 1'b1;
  endfunction

  function automatic bit lookup_byte(input logic [7:0] b, input logic last,
                                     output result_t res);
    bit          hit;
    logic [15:0] pos;
    hit = 1'b0;
    res = '0;
    pos = pos_cnt;
    case (ph)
      PH_NAME_LEN: begin
        remain   = {8'd0, b};
        name_idx = '0;
        name_ok  = (8'(key_len) == b) && (b <= MAX_KEY_BYTES);
        ph       = (b != 8'd0) ? PH_NAME : PH_TYPE;
      end
      PH_NAME: begin
        if (name_ok && ((name_idx >= MAX_KEY_BYTES) || (key_byte(name_idx) != b)))
          name_ok = 1'b0;
        name_idx = name_idx + 8'd1;
        remain   = remain - 16'd1;
        if (remain == 16'd0) ph = PH_TYPE;
      end
      PH_TYPE: begin
        shift_val = '0;
        held_dec  = '0;
        if (b == CHAR_S) begin
          cur_type = TYPE_STRING;
          ph       = PH_LEN_HI;
        end else if (b == CHAR_I || b == CHAR_T) begin
          cur_type = (b == CHAR_I) ? TYPE_INTEGER : TYPE_TIME;
          remain   = 16'd4;
          ph       = PH_BODY;
        end else if (b == CHAR_D) begin
          cur_type = TYPE_DECIMAL;
          ph       = PH_DECIMALS;
        end else begin
          cur_type       = TYPE_NONE;
          res.error_code = ERR_UNSUPPORTED;
          hit            = 1'b1;
          ph             = PH_DONE;
        end
      end
      PH_LEN_HI: begin
        shift_val = {24'd0, b};
        ph        = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        shift_val = {16'd0, shift_val[7:0], b};
        remain    = shift_val[15:0];
        if (remain == 16'd0) hit = close_field(pos, res);
        else ph = PH_BODY;
      end
      PH_DECIMALS: begin
        held_dec = b;
        remain   = 16'd4;
        ph       = PH_BODY;
      end
      PH_BODY: begin
        if (cur_type != TYPE_STRING) shift_val = {shift_val[23:0], b};
        remain = remain - 16'd1;
        if (remain == 16'd0) hit = close_field(pos, res);
      end
      default: ;
    endcase
    pos_cnt = pos_cnt + 16'd1;
    if (last) begin
      if (!hit && ph != PH_DONE) begin
        res            = '0;
        res.error_code = (ph == PH_NAME_LEN) ? ERR_OK : ERR_TRUNCATED;
        hit            = 1'b1;
      end
      clear_parse();
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < 100)
      $display("ERROR result %0d %s: got %0h expected %0h", results_seen, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{found, field_kind, data_offset, string_length, decimal_places,
              field_value, error_code};
      if (lookup_results_q.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(got.error_code), 32'(ERR_OK));
      end else begin
        want = lookup_results_q.pop_front();
        if (got.found !== want.found)
          report_mismatch("found", 32'(got.found), 32'(want.found));
        if (got.field_kind !== want.field_kind)
          report_mismatch("field_kind", 32'(got.field_kind), 32'(want.field_kind));
        if (got.data_offset !== want.data_offset)
          report_mismatch("data_offset", 32'(got.data_offset), 32'(want.data_offset));
        if (got.string_length !== want.string_length)
          report_mismatch("string_length", 32'(got.string_length),
                          32'(want.string_length));
        if (got.decimal_places !== want.decimal_places)
          report_mismatch("decimal_places", 32'(got.decimal_places),
                          32'(want.decimal_places));
        if (got.field_value !== want.field_value)
          report_mismatch("field_value", got.field_value, want.field_value);
        if (got.error_code !== want.error_code)
          report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
      end
      results_seen++;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver stall pattern
  initial begin
    int run;
    out_stall <= 1'b0;
    @(negedge clk);
    forever begin
      run = pick_gap();
      if (run > 0) begin
        out_stall <= 1'b1;
        repeat (run) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    result_t res;
    int      gap;
    in_valid   <= 1'b1;
    table_byte <= b;
    last_byte  <= last;
    do @(posedge clk); while (in_stall);
    if (lookup_byte(b, last, res)) lookup_results_q.push_back(res);
    bytes_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_table();
    for (int i = 0; i < tbl.size(); i++) send_byte(tbl[i], i == tbl.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (lookup_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KEY_LENGTH:  key_len = val[5:0];
      CFG_KEY_BYTES_0: key_words[0] = val;
      CFG_KEY_BYTES_1: key_words[1] = val;
      CFG_KEY_BYTES_2: key_words[2] = val;
      CFG_KEY_BYTES_3: key_words[3] = val;
      default: ;
    endcase
  endtask

  task automatic set_key(input logic [5:0] len, input logic [63:0] w0, input logic [63:0] w1,
                         input logic [63:0] w2, input logic [63:0] w3);
    wait_drained();
    write_reg(CFG_KEY_LENGTH, {58'd0, len});
    write_reg(CFG_KEY_BYTES_0, w0);
    write_reg(CFG_KEY_BYTES_1, w1);
    write_reg(CFG_KEY_BYTES_2, w2);
    write_reg(CFG_KEY_BYTES_3, w3);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic push_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      default: v = $urandom;
    endcase
    tbl.push_back(v[31:24]);
    tbl.push_back(v[23:16]);
    tbl.push_back(v[15:8]);
    tbl.push_back(v[7:0]);
  endtask

  task automatic add_field();
    int         r;
    int         nlen;
    int         flip;
    int         slen;
    logic [7:0] b;
    logic [7:0] tcode;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      // key-shaped name, sometimes with one bit flipped
      nlen = key_len;
      flip = (r >= 4 && nlen > 0) ? $urandom_range(0, nlen - 1) : -1;
      tbl.push_back(8'(nlen));
      for (int i = 0; i < nlen; i++) begin
        b = (i < MAX_KEY_BYTES) ? key_byte(i) : 8'($urandom);
        if (i == flip) b = b ^ (8'd1 << $urandom_range(0, 7));
        tbl.push_back(b);
      end
    end else begin
      nlen = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
      tbl.push_back(8'(nlen));
      repeat (nlen) tbl.push_back(8'($urandom));
    end
    r = $urandom_range(0, 19);
    if (r < 5) tcode = CHAR_S;
    else if (r < 10) tcode = CHAR_I;
    else if (r < 14) tcode = CHAR_T;
    else if (r < 19) tcode = CHAR_D;
    else tcode = 8'($urandom);
    tbl.push_back(tcode);
    if (tcode == CHAR_S) begin
      slen = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 6);
      tbl.push_back(8'(slen >> 8));
      tbl.push_back(8'(slen));
      repeat (slen) tbl.push_back(8'($urandom));
    end else if (tcode == CHAR_I || tcode == CHAR_T) begin
      push_value();
    end else if (tcode == CHAR_D) begin
      tbl.push_back(8'($urandom));
      push_value();
    end
  endtask

  task automatic build_table();
    int r;
    int n;
    tbl.delete();
    r = $urandom_range(0, 19);
    if (r == 0) begin
      repeat ($urandom_range(1, 20)) tbl.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) add_field();
      if (r < 4) begin
        // cut the table short
        n = $urandom_range(1, tbl.size());
        while (tbl.size() > n) void'(tbl.pop_back());
      end
    end
  endtask

  task automatic run_random_tables(input int target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      calm = ($urandom_range(0, 4) == 0);
      build_table();
      send_table();
      if ($urandom_range(0, 14) == 0) wait_drained();
    end
    calm = 1'b0;
  endtask

  // Key registers are zero after reset, so the empty name is the key here.
  task automatic test_empty_key();
    tbl = '{8'h00, CHAR_S, 8'h00, 8'h00};
    send_table();
    tbl = '{8'h00, 8'hFF};
    send_table();
    tbl = '{8'h00};
    send_table();
    tbl = '{8'h01, 8'h41, CHAR_T, 8'h00, 8'h00, 8'h00, 8'h01};
    send_table();
    tbl = '{8'h00, CHAR_D, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00};
    send_table();
    tbl = '{8'h00, CHAR_I, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_table();
    run_random_tables(100);
  endtask

  task automatic test_single_byte_key();
    set_key(6'd1, rand_word(), rand_word(), rand_word(), rand_word());
    run_random_tables(180);
  endtask

  task automatic test_all_ones_key();
    set_key(6'($urandom_range(2, 8)), '1, '1, '1, '1);
    run_random_tables(200);
  endtask

  task automatic test_full_key();
    set_key(6'(MAX_KEY_BYTES), rand_word(), rand_word(), rand_word(), rand_word());
    run_random_tables(230);
  endtask

  task automatic test_oversized_key();
    set_key(6'd63, rand_word(), rand_word(), rand_word(), rand_word());
    run_random_tables(150);
    set_key(6'($urandom_range(33, 62)), rand_word(), rand_word(), rand_word(), rand_word());
    run_random_tables(150);
  endtask

  task automatic test_zero_key_bytes();
    set_key(6'($urandom_range(1, 6)), '0, '0, '0, '0);
    run_random_tables(200);
  endtask

  // A matching string whose length needs both prefix bytes.
  task automatic test_long_string();
    set_key(6'd3, rand_word(), rand_word(), rand_word(), rand_word());
    calm = 1'b1;
    tbl.delete();
    tbl.push_back(8'd2);
    repeat (2) tbl.push_back(8'($urandom));
    tbl.push_back(CHAR_S);
    tbl.push_back(8'h00);
    tbl.push_back(8'd5);
    repeat (5) tbl.push_back(8'($urandom));
    tbl.push_back(8'd3);
    for (int i = 0; i < 3; i++) tbl.push_back(key_byte(i));
    tbl.push_back(CHAR_S);
    tbl.push_back(8'h01);
    tbl.push_back(8'h00);
    repeat (256) tbl.push_back(8'($urandom));
    send_table();
    calm = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    table_byte   = '0;
    last_byte    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_KEY_LENGTH;
    cfg_data     = '0;
    calm         = 1'b0;
    err_count    = 0;
    results_seen = 0;
    bytes_sent   = 0;
    key_len      = '0;
    for (int i = 0; i < KEY_WORDS; i++) key_words[i] = '0;
    clear_parse();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_key();
    test_single_byte_key();
    test_all_ones_key();
    test_full_key();
    test_oversized_key();
    test_zero_key_bytes();
    test_long_string();

    wait_drained();
    repeat (10) @(negedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
